@@ src/dsb_pkg.sv @@
`timescale 1ns / 1ps

package dsb_pkg;

    // Fixed field widths of the channels.
    localparam int FUNC_W     = 2;
    localparam int NUM_W      = 31;
    localparam int NODE_W     = 12;
    localparam int POS_W      = 10;
    localparam int OUT_FILL_W = 11;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 1;

    // A node record holds a bucket number, or all ones for "no bucket".
    localparam int              REC_W    = 32;
    localparam logic [REC_W-1:0] REC_NONE = '1;

    // The shared restoring divider produces one quotient bit per cycle.
    localparam int DIV_W      = 16;
    localparam int DIV_STEPS  = NUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Default sizes handed to the top level.
    localparam int MAX_NODES_DEF   = 4096;
    localparam int MAX_BUCKETS_DEF = 64;
    localparam int BUCKET_CAP_DEF  = 1024;

    // Register reset values and the ring size that follows from them.
    localparam logic [CFG_W-1:0] STEP_WIDTH_RST = 16'd1;
    localparam logic [CFG_W-1:0] MAX_WEIGHT_RST = 16'd63;
    localparam int RING_RST_RAW = int'(MAX_WEIGHT_RST) / int'(STEP_WIDTH_RST) + 1;

    // Register indexes of the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_STEP_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WEIGHT = 1'd1;

    // Operation codes.
    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 2'd0,
        FN_CLEAR  = 2'd1,
        FN_READ   = 2'd2,
        FN_QUERY  = 2'd3
    } func_t;

endpackage

@@ src/dsb_if.sv @@
`timescale 1ns / 1ps

// Command channel.
interface dsb_in_if
    import dsb_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [NUM_W-1:0]    bucket_number;
    logic [NODE_W-1:0]   node;
    logic [POS_W-1:0]    entry_pos;

    modport source (output valid, func, bucket_number, node, entry_pos, input ready);
    modport sink   (input valid, func, bucket_number, node, entry_pos, output ready);
endinterface

// Result channel.
interface dsb_out_if
    import dsb_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [NODE_W-1:0]     entry_node;
    logic [OUT_FILL_W-1:0] bucket_fill;
    logic                  bucket_empty;
    logic                  all_empty;
    logic                  inserted;
    logic                  overflow;

    modport source (output valid, entry_node, bucket_fill, bucket_empty, all_empty,
                    inserted, overflow, input ready);
    modport sink   (input valid, entry_node, bucket_fill, bucket_empty, all_empty,
                    inserted, overflow, output ready);
endinterface

// Register write channel.
interface dsb_cfg_if
    import dsb_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ src/delta_stepping_bucket_store_core.sv @@
`timescale 1ns / 1ps

// Channel   Modport  Transfer carries
// --------  -------  ---------------------------------------------------------
// in_ch     sink     func, bucket_number, node, entry_pos
// out_ch    source   entry_node, bucket_fill, bucket_empty, all_empty,
//                    inserted, overflow
// cfg_ch    sink     index, data (0 step_width, 1 max_weight)
//
// After a command transfer, the shared bit-serial divider reduces
// bucket_number modulo the ring size in state S_MOD. Memory access follows
// in S_BASE and S_LOOK (and S_RD_WAIT for a read of a stored entry), then
// S_RESULT loads the result register, and the next command can transfer
// once the block is back in S_IDLE. A clear also steps through S_CLR_RD and
// S_CLR_WR for each entry of the bucket, since each entry is read from the
// entry RAM and then its node record is written. After reset the node record
// RAM is swept to "no bucket", one entry per cycle; in_ch is not ready during
// the sweep, while cfg_ch is. A register write makes the divider recompute
// the ring size before the next command is taken. A stalled out_ch holds the
// finished result and blocks only the hand-off of the following one.

module delta_stepping_bucket_store_core
    import dsb_pkg::*;
#(
    parameter int MAX_NODES   = MAX_NODES_DEF,
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
    parameter int BUCKET_CAP  = BUCKET_CAP_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    dsb_in_if.sink    in_ch,
    dsb_out_if.source out_ch,
    dsb_cfg_if.sink   cfg_ch
);

    // Address and count widths derived from the sizes.
    localparam int     NODE_AW    = $clog2(MAX_NODES);
    localparam int     BKT_AW     = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam longint ENT_DEPTH  = longint'(MAX_BUCKETS) * longint'(BUCKET_CAP);
    localparam int     ENT_AW     = (ENT_DEPTH > 1) ? $clog2(ENT_DEPTH) : 1;
    localparam int     FILL_W     = $clog2(BUCKET_CAP + 1);
    localparam int     RING_W     = $clog2(MAX_BUCKETS + 1);
    localparam int     RING_RST   = (RING_RST_RAW > MAX_BUCKETS) ? MAX_BUCKETS
                                                                 : RING_RST_RAW;

    // One-hot sequencer states.
    typedef enum logic [9:0] {
        S_INIT    = 10'b00_0000_0001,
        S_IDLE    = 10'b00_0000_0010,
        S_RING    = 10'b00_0000_0100,
        S_MOD     = 10'b00_0000_1000,
        S_BASE    = 10'b00_0001_0000,
        S_LOOK    = 10'b00_0010_0000,
        S_CLR_RD  = 10'b00_0100_0000,
        S_CLR_WR  = 10'b00_1000_0000,
        S_RD_WAIT = 10'b01_0000_0000,
        S_RESULT  = 10'b10_0000_0000
    } state_t;

    // Control state.
    state_t                 state_reg, state_next;
    logic                   ring_dirty_reg, ring_dirty_next;
    logic [CFG_W-1:0]       step_width_reg, step_width_next;
    logic [CFG_W-1:0]       max_weight_reg, max_weight_next;
    logic [RING_W-1:0]      ring_reg, ring_next;
    logic [MAX_BUCKETS-1:0] nonempty_reg, nonempty_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [NODE_AW-1:0]     init_reg, init_next;
    logic                   out_valid_reg, out_valid_next;

    // Shared divider registers: the dividend shifts out at the top while the
    // quotient shifts in at the bottom.
    logic [NUM_W-1:0]       div_dvd_reg, div_dvd_next;
    logic [DIV_W-1:0]       div_rem_reg, div_rem_next;
    logic [DIV_W-1:0]       div_dsr_reg, div_dsr_next;

    // Command being worked on.
    func_t                  func_reg, func_next;
    logic [NUM_W-1:0]       num_reg, num_next;
    logic [NODE_W-1:0]      node_reg, node_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [BKT_AW-1:0]      b_reg, b_next;
    logic [ENT_AW-1:0]      base_reg, base_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [FILL_W-1:0]      j_reg, j_next;
    logic [NODE_W-1:0]      entry_reg, entry_next;
    logic                   ins_reg, ins_next;
    logic                   ovf_reg, ovf_next;

    // Result register.
    logic [NODE_W-1:0]      o_entry_reg, o_entry_next;
    logic [OUT_FILL_W-1:0]  o_fill_reg, o_fill_next;
    logic                   o_bempty_reg, o_bempty_next;
    logic                   o_aempty_reg, o_aempty_next;
    logic                   o_ins_reg, o_ins_next;
    logic                   o_ovf_reg, o_ovf_next;

    // Memories and their ports.
    logic [REC_W-1:0]       rec_mem [MAX_NODES];
    logic [NODE_W-1:0]      ent_mem [ENT_DEPTH];
    logic [FILL_W-1:0]      fill_mem [MAX_BUCKETS];

    logic                   rec_we;
    logic [NODE_AW-1:0]     rec_waddr;
    logic [REC_W-1:0]       rec_wdata;
    logic [NODE_AW-1:0]     rec_raddr;
    logic [REC_W-1:0]       rec_rd_reg;

    logic                   ent_we;
    logic [ENT_AW-1:0]      ent_waddr;
    logic [NODE_W-1:0]      ent_wdata;
    logic [ENT_AW-1:0]      ent_raddr;
    logic [NODE_W-1:0]      ent_rd_reg;

    logic                   fill_we;
    logic [FILL_W-1:0]      fill_wdata;
    logic [BKT_AW-1:0]      fill_raddr;
    logic [FILL_W-1:0]      fill_rd_reg;

    // Helper signals.
    logic [DIV_W:0]         rem_sh;
    logic                   div_ge;
    logic [DIV_W-1:0]       rem_new;
    logic [NUM_W-1:0]       dvd_new;
    logic [MAX_BUCKETS-1:0] ring_mask;
    logic                   in_fire;
    logic                   cfg_fire;
    logic                   node_ok;
    logic                   ent_node_ok;
    logic [NODE_AW+NODE_W-1:0] node_ext;
    logic [NODE_AW+NODE_W-1:0] ent_node_ext;
    logic [FILL_W-1:0]      fill_cur;
    logic [FILL_W+OUT_FILL_W-1:0] fill_ext;

    assign in_ch.ready  = (state_reg == S_IDLE) && !ring_dirty_reg && !cfg_ch.valid;
    assign cfg_ch.ready = (state_reg == S_IDLE) || (state_reg == S_INIT);
    assign in_fire      = in_ch.valid && in_ch.ready;
    assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.entry_node   = o_entry_reg;
    assign out_ch.bucket_fill  = o_fill_reg;
    assign out_ch.bucket_empty = o_bempty_reg;
    assign out_ch.all_empty    = o_aempty_reg;
    assign out_ch.inserted     = o_ins_reg;
    assign out_ch.overflow     = o_ovf_reg;

    // One step of the shared restoring divider.
    assign rem_sh  = {div_rem_reg, div_dvd_reg[NUM_W-1]};
    assign div_ge  = rem_sh >= {1'b0, div_dsr_reg};
    assign rem_new = div_ge ? DIV_W'(rem_sh - {1'b0, div_dsr_reg}) : rem_sh[DIV_W-1:0];
    assign dvd_new = {div_dvd_reg[NUM_W-2:0], div_ge};

    // Node numbers as record addresses, and their range checks.
    assign node_ext     = {{NODE_AW{1'b0}}, node_reg};
    assign ent_node_ext = {{NODE_AW{1'b0}}, ent_rd_reg};
    assign node_ok      = 32'(node_reg) < 32'(MAX_NODES);
    assign ent_node_ok  = 32'(ent_rd_reg) < 32'(MAX_NODES);
    assign rec_raddr    = node_ext[NODE_AW-1:0];

    // The bucket index is the divider remainder once the modulo is done.
    assign fill_raddr = div_rem_reg[BKT_AW-1:0];

    // A bucket that is marked empty reads as zero fill whatever its RAM holds.
    assign fill_cur = nonempty_reg[b_reg] ? fill_rd_reg : '0;
    assign fill_ext = {{OUT_FILL_W{1'b0}}, fill_reg};

    // Buckets outside the current ring are ignored by the all-empty flag.
    always_comb
    begin
        for (int i = 0; i < MAX_BUCKETS; i++)
        begin
            ring_mask[i] = 32'(i) < 32'(ring_reg);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        ring_dirty_next = ring_dirty_reg;
        step_width_next = step_width_reg;
        max_weight_next = max_weight_reg;
        ring_next       = ring_reg;
        nonempty_next   = nonempty_reg;
        cnt_next        = cnt_reg;
        init_next       = init_reg;
        out_valid_next  = out_valid_reg;
        div_dvd_next    = div_dvd_reg;
        div_rem_next    = div_rem_reg;
        div_dsr_next    = div_dsr_reg;
        func_next       = func_reg;
        num_next        = num_reg;
        node_next       = node_reg;
        pos_next        = pos_reg;
        b_next          = b_reg;
        base_next       = base_reg;
        fill_next       = fill_reg;
        j_next          = j_reg;
        entry_next      = entry_reg;
        ins_next        = ins_reg;
        ovf_next        = ovf_reg;
        o_entry_next    = o_entry_reg;
        o_fill_next     = o_fill_reg;
        o_bempty_next   = o_bempty_reg;
        o_aempty_next   = o_aempty_reg;
        o_ins_next      = o_ins_reg;
        o_ovf_next      = o_ovf_reg;

        rec_we     = 1'b0;
        rec_waddr  = rec_raddr;
        rec_wdata  = REC_NONE;
        ent_we     = 1'b0;
        ent_waddr  = base_reg + ENT_AW'(fill_cur);
        ent_wdata  = node_reg;
        ent_raddr  = base_reg + ENT_AW'(j_reg);
        fill_we    = 1'b0;
        fill_wdata = FILL_W'(fill_cur + 1'b1);

        if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        // Register writes; the ring size is recomputed before the next command.
        if (cfg_fire)
        begin
            case (cfg_ch.index)
                REG_STEP_WIDTH:
                begin
                    step_width_next = cfg_ch.data;
                    ring_dirty_next = 1'b1;
                end
                REG_MAX_WEIGHT:
                begin
                    max_weight_next = cfg_ch.data;
                    ring_dirty_next = 1'b1;
                end
                default:
                begin
                    ring_dirty_next = ring_dirty_reg;
                end
            endcase
        end

        case (state_reg)
            S_INIT:
            begin
                // Sweep every node record to "no bucket".
                rec_we    = 1'b1;
                rec_waddr = init_reg;
                rec_wdata = REC_NONE;
                init_next = init_reg + 1'b1;
                if (32'(init_reg) == 32'(MAX_NODES - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (ring_dirty_reg && !cfg_ch.valid)
                begin
                    // Ring size is max_weight / step_width + 1, clamped.
                    div_dvd_next    = NUM_W'(max_weight_reg);
                    div_rem_next    = '0;
                    div_dsr_next    = (step_width_reg == '0) ? DIV_W'(1) : step_width_reg;
                    cnt_next        = '0;
                    ring_dirty_next = 1'b0;
                    state_next      = S_RING;
                end
                else if (in_fire)
                begin
                    func_next    = func_t'(in_ch.func);
                    num_next     = in_ch.bucket_number;
                    node_next    = in_ch.node;
                    pos_next     = in_ch.entry_pos;
                    div_dvd_next = in_ch.bucket_number;
                    div_rem_next = '0;
                    div_dsr_next = DIV_W'(ring_reg);
                    cnt_next     = '0;
                    state_next   = S_MOD;
                end
            end

            S_RING:
            begin
                div_dvd_next = dvd_new;
                div_rem_next = rem_new;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    if (dvd_new >= NUM_W'(MAX_BUCKETS))
                    begin
                        ring_next = RING_W'(MAX_BUCKETS);
                    end
                    else
                    begin
                        ring_next = RING_W'(dvd_new + 1'b1);
                    end
                    state_next = S_IDLE;
                end
            end

            S_MOD:
            begin
                div_dvd_next = dvd_new;
                div_rem_next = rem_new;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_BASE;
                end
            end

            S_BASE:
            begin
                // Fill count and node record are read here; both arrive next cycle.
                b_next     = fill_raddr;
                base_next  = ENT_AW'(fill_raddr) * ENT_AW'(BUCKET_CAP);
                state_next = S_LOOK;
            end

            S_LOOK:
            begin
                entry_next = '0;
                ins_next   = 1'b0;
                ovf_next   = 1'b0;
                fill_next  = fill_cur;
                state_next = S_RESULT;
                case (func_reg)
                    FN_INSERT:
                    begin
                        // Only a node with no bucket or a later one is appended.
                        if (node_ok && (rec_rd_reg > {1'b0, num_reg}))
                        begin
                            if (32'(fill_cur) < 32'(BUCKET_CAP))
                            begin
                                rec_we                = 1'b1;
                                rec_waddr             = rec_raddr;
                                rec_wdata             = {1'b0, num_reg};
                                ent_we                = 1'b1;
                                fill_we               = 1'b1;
                                fill_next             = fill_wdata;
                                nonempty_next[b_reg]  = 1'b1;
                                ins_next              = 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                    end
                    FN_CLEAR:
                    begin
                        j_next = '0;
                        if (fill_cur != '0)
                        begin
                            state_next = S_CLR_RD;
                        end
                    end
                    FN_READ:
                    begin
                        if (32'(pos_reg) < 32'(fill_cur))
                        begin
                            ent_raddr  = base_reg + ENT_AW'(pos_reg);
                            state_next = S_RD_WAIT;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESULT;
                    end
                endcase
            end

            S_CLR_RD:
            begin
                ent_raddr  = base_reg + ENT_AW'(j_reg);
                state_next = S_CLR_WR;
            end

            S_CLR_WR:
            begin
                // Every listed node loses its record, stale entries included.
                if (ent_node_ok)
                begin
                    rec_we    = 1'b1;
                    rec_waddr = ent_node_ext[NODE_AW-1:0];
                    rec_wdata = REC_NONE;
                end
                j_next = j_reg + 1'b1;
                if (FILL_W'(j_reg + 1'b1) == fill_reg)
                begin
                    nonempty_next[b_reg] = 1'b0;
                    fill_next            = '0;
                    state_next           = S_RESULT;
                end
                else
                begin
                    state_next = S_CLR_RD;
                end
            end

            S_RD_WAIT:
            begin
                entry_next = ent_rd_reg;
                state_next = S_RESULT;
            end

            S_RESULT:
            begin
                // Hand the result over once the output register is free.
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    o_entry_next   = entry_reg;
                    o_fill_next    = fill_ext[OUT_FILL_W-1:0];
                    o_bempty_next  = fill_reg == '0;
                    o_aempty_next  = (nonempty_reg & ring_mask) == '0;
                    o_ins_next     = ins_reg;
                    o_ovf_next     = ovf_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            ring_dirty_reg <= 1'b0;
            step_width_reg <= STEP_WIDTH_RST;
            max_weight_reg <= MAX_WEIGHT_RST;
            ring_reg       <= RING_W'(RING_RST);
            nonempty_reg   <= '0;
            cnt_reg        <= '0;
            init_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ring_dirty_reg <= ring_dirty_next;
            step_width_reg <= step_width_next;
            max_weight_reg <= max_weight_next;
            ring_reg       <= ring_next;
            nonempty_reg   <= nonempty_next;
            cnt_reg        <= cnt_next;
            init_reg       <= init_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_dvd_reg  <= div_dvd_next;
        div_rem_reg  <= div_rem_next;
        div_dsr_reg  <= div_dsr_next;
        func_reg     <= func_next;
        num_reg      <= num_next;
        node_reg     <= node_next;
        pos_reg      <= pos_next;
        b_reg        <= b_next;
        base_reg     <= base_next;
        fill_reg     <= fill_next;
        j_reg        <= j_next;
        entry_reg    <= entry_next;
        ins_reg      <= ins_next;
        ovf_reg      <= ovf_next;
        o_entry_reg  <= o_entry_next;
        o_fill_reg   <= o_fill_next;
        o_bempty_reg <= o_bempty_next;
        o_aempty_reg <= o_aempty_next;
        o_ins_reg    <= o_ins_next;
        o_ovf_reg    <= o_ovf_next;
    end

    // Node record RAM.
    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            rec_mem[rec_waddr] <= rec_wdata;
        end
        rec_rd_reg <= rec_mem[rec_raddr];
    end

    // Bucket entry RAM.
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        ent_rd_reg <= ent_mem[ent_raddr];
    end

    // Bucket fill RAM; the nonempty flags stand in for its reset.
    always_ff @(posedge clk)
    begin
        if (fill_we)
        begin
            fill_mem[b_reg] <= fill_wdata;
        end
        fill_rd_reg <= fill_mem[fill_raddr];
    end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

// Testbench for the delta-stepping bucket store. Commands are sent on in_ch,
// results are taken from out_ch, and the ring geometry is set on cfg_ch.
// A predictor in this module keeps its own node records, bucket contents and
// fill counts. For every command transfer it works out the result the block
// must return. A checker compares each result transfer with the oldest
// pending prediction, field by field.
module tb;
    import dsb_pkg::*;

    localparam int NODE_COUNT  = MAX_NODES_DEF;
    localparam int BUCKETS     = MAX_BUCKETS_DEF;
    localparam int CAPACITY    = BUCKET_CAP_DEF;
    // The slowest correct step is the post-reset record sweep or a clear of a
    // full bucket. Both stay far below this.
    localparam int STALL_LIMIT = 30000;

    typedef struct packed {
        logic [NODE_W-1:0]     entry_node;
        logic [OUT_FILL_W-1:0] bucket_fill;
        logic                  bucket_empty;
        logic                  all_empty;
        logic                  inserted;
        logic                  overflow;
    } bucket_report_t;

    logic clk;
    logic rst_n;

    dsb_in_if  in_ch ();
    dsb_out_if out_ch ();
    dsb_cfg_if cfg_ch ();

    delta_stepping_bucket_store_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    // Predictor state. Every 12-bit node is below the node count, so no
    // command can name a node outside the record table.
    logic [REC_W-1:0]  node_record [NODE_COUNT];
    logic [NODE_W-1:0] bucket_slot [BUCKETS][CAPACITY];
    int unsigned       bucket_count [BUCKETS];
    int unsigned       ring_len;
    logic [CFG_W-1:0]  step_reg;
    logic [CFG_W-1:0]  weight_reg;

    // Predicted results, oldest first.
    bucket_report_t expected_reports[$];

    int mismatches;
    int quiet_cycles;
    int stall_left;
    // While set, neither side of the block idles.
    bit steady;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The ring covers max_weight / step_width + 1 buckets, capped at the
    // number of physical buckets. A zero step width counts as one.
    function automatic void update_ring();
        int unsigned w;
        int unsigned n;
        w = (step_reg == 0) ? 1 : step_reg;
        n = weight_reg / w + 1;
        ring_len = (n > BUCKETS) ? BUCKETS : n;
    endfunction

    // Applies one command to the predictor state and returns what the block
    // must report for it.
    function automatic bucket_report_t apply_bucket_op(func_t op, logic [NUM_W-1:0] num,
                                                       logic [NODE_W-1:0] nd,
                                                       logic [POS_W-1:0] pos);
        bucket_report_t rep;
        int unsigned    b;
        int unsigned    j;
        rep = '0;
        b = num % ring_len;
        case (op)
            FN_INSERT:
            begin
                // A node moves only to an earlier bucket than the one on
                // record; "no bucket" is all ones and loses to any number.
                if (node_record[nd] > {1'b0, num})
                begin
                    if (bucket_count[b] < CAPACITY)
                    begin
                        node_record[nd] = {1'b0, num};
                        bucket_slot[b][bucket_count[b]] = nd;
                        bucket_count[b]++;
                        rep.inserted = 1'b1;
                    end
                    else
                    begin
                        rep.overflow = 1'b1;
                    end
                end
            end
            FN_CLEAR:
            begin
                // Stale entries also drop their node's record, even if the
                // node now sits in some other bucket.
                for (j = 0; j < bucket_count[b]; j++)
                    node_record[bucket_slot[b][j]] = REC_NONE;
                bucket_count[b] = 0;
            end
            FN_READ:
            begin
                if (pos < bucket_count[b])
                    rep.entry_node = bucket_slot[b][pos];
            end
            default: ;
        endcase
        rep.bucket_fill  = OUT_FILL_W'(bucket_count[b]);
        rep.bucket_empty = (bucket_count[b] == 0);
        rep.all_empty    = 1'b1;
        for (j = 0; j < ring_len; j++)
            if (bucket_count[j] != 0)
                rep.all_empty = 1'b0;
        return rep;
    endfunction

    function automatic void report_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    // Result checker: every result transfer is matched with the oldest
    // prediction.
    always @(posedge clk)
    begin
        bucket_report_t want;
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (expected_reports.size() == 0)
            begin
                mismatches++;
                $display("%0t: result expected none actual fill %0h node %0h", $time,
                         out_ch.bucket_fill, out_ch.entry_node);
            end
            else
            begin
                want = expected_reports.pop_front();
                report_field("entry_node", want.entry_node, out_ch.entry_node);
                report_field("bucket_fill", want.bucket_fill, out_ch.bucket_fill);
                report_field("bucket_empty", want.bucket_empty, out_ch.bucket_empty);
                report_field("all_empty", want.all_empty, out_ch.all_empty);
                report_field("inserted", want.inserted, out_ch.inserted);
                report_field("overflow", want.overflow, out_ch.overflow);
            end
        end
    end

    // Result receiver: always ready while steady is set; otherwise drops ready at random about
    // 30 percent of the time, with an occasional long stall so that a finished result has to wait.
    always @(negedge clk)
    begin
        if (steady)
        begin
            out_ch.ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end
        else if ($urandom_range(99) < 2)
        begin
            stall_left = $urandom_range(20, 120);
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(99) >= 30);
        end
    end

    // Watchdog: ends the run when no transfer of any kind happens for too long.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("delta_stepping_bucket_store_core: mismatch");
            $finish;
        end
    end

    // Sends one command and records its prediction at the transfer. Starts
    // and ends at a falling edge. Valid stays high when no gap follows, so a
    // command issued right after goes out back to back.
    task automatic issue_command(func_t op, logic [NUM_W-1:0] num, logic [NODE_W-1:0] nd,
                                 logic [POS_W-1:0] pos);
        bucket_report_t rep;
        in_ch.valid         <= 1'b1;
        in_ch.func          <= op;
        in_ch.bucket_number <= num;
        in_ch.node          <= nd;
        in_ch.entry_pos     <= pos;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        rep = apply_bucket_op(op, num, nd, pos);
        expected_reports = {expected_reports, rep};
        @(negedge clk);
        if (!steady && $urandom_range(99) < 30)
        begin
            in_ch.valid <= 1'b0;
            // Short gaps mostly, and now and then one long enough to cover a
            // whole command.
            repeat (($urandom_range(3) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 3))
                @(negedge clk);
        end
    endtask

    // Stops sending and waits until every predicted result has arrived.
    task automatic quiesce();
        in_ch.valid <= 1'b0;
        do @(negedge clk); while (expected_reports.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        if (idx == REG_STEP_WIDTH)
            step_reg = val;
        else
            weight_reg = val;
        update_ring();
        @(negedge clk);
    endtask

    // Registers change only while the block is idle. Each command yields a
    // result, so an empty prediction queue means nothing is in flight.
    task automatic configure(logic [CFG_W-1:0] step, logic [CFG_W-1:0] weight);
        quiesce();
        write_reg(REG_STEP_WIDTH, step);
        write_reg(REG_MAX_WEIGHT, weight);
        cfg_ch.valid <= 1'b0;
    endtask

    // Right after reset every bucket is empty, whatever the bucket number.
    task automatic test_reset_state();
        issue_command(FN_QUERY, '0, '0, '0);
        issue_command(FN_QUERY, 31'h7FFF_FFFF, 12'hFFF, 10'h3FF);
        issue_command(FN_READ, 31'd17, '0, '0);
        issue_command(FN_CLEAR, 31'd63, '0, '0);
    endtask

    // Insert ordering, stale entries and reads, on the 64-bucket reset ring.
    task automatic test_insert_rules();
        issue_command(FN_INSERT, '0, 12'h000, '0);
        issue_command(FN_INSERT, 31'h7FFF_FFFF, 12'hFFF, '0);
        // An earlier bucket takes the node again; the old entry stays.
        issue_command(FN_INSERT, 31'd5, 12'hFFF, '0);
        // A later or the same bucket is refused.
        issue_command(FN_INSERT, 31'd10, 12'hFFF, '0);
        issue_command(FN_INSERT, 31'd5, 12'hFFF, '0);
        issue_command(FN_INSERT, 31'd69, 12'hAAA, '0);
        issue_command(FN_READ, 31'd63, '0, 10'd0);
        issue_command(FN_READ, 31'd5, '0, 10'd1);
        issue_command(FN_READ, 31'd5, '0, 10'd2);
        issue_command(FN_READ, 31'd5, '0, 10'h3FF);
        // Clearing the stale copy forgets the node's newer bucket too, so an
        // insert behind that bucket is taken again.
        issue_command(FN_CLEAR, 31'd63, '0, '0);
        issue_command(FN_INSERT, 31'd6, 12'hFFF, '0);
        issue_command(FN_QUERY, 31'd5, '0, '0);
        issue_command(FN_READ, 31'd0, '0, 10'd0);
    endtask

    // Ring geometry: zero step, single bucket, clamp, and a shrink that hides
    // a filled bucket until the ring grows back.
    task automatic test_ring_config();
        configure(16'd0, 16'd9);
        issue_command(FN_INSERT, 31'd23, 12'h555, '0);
        issue_command(FN_READ, 31'd3, '0, 10'd0);
        issue_command(FN_QUERY, 31'd13, '0, '0);
        configure(16'd1, 16'd0);
        issue_command(FN_QUERY, 31'd12345, '0, '0);
        issue_command(FN_READ, 31'd999, '0, 10'd0);
        configure(16'hFFFF, 16'hFFFF);
        issue_command(FN_QUERY, 31'd1, '0, '0);
        configure(16'd1, 16'hFFFF);
        issue_command(FN_INSERT, 31'd40, 12'h309, '0);
        configure(16'd1, 16'd6);
        issue_command(FN_QUERY, 31'd0, '0, '0);
        issue_command(FN_QUERY, 31'd6, '0, '0);
        configure(STEP_WIDTH_RST, MAX_WEIGHT_RST);
        issue_command(FN_READ, 31'd40, '0, 10'd0);
    endtask

    // Fills the single bucket of a one-bucket ring to capacity, checks that
    // further inserts are dropped, then clears it in one long walk.
    task automatic test_full_bucket();
        logic [NODE_W-1:0] next_node;
        next_node = 12'd1024;
        configure(16'd1, 16'd0);
        issue_command(FN_CLEAR, '0, '0, '0);
        // A long stretch with no idling on either side.
        steady = 1'b1;
        while (bucket_count[0] < CAPACITY)
        begin
            issue_command(FN_INSERT, NUM_W'($urandom), next_node, POS_W'($urandom));
            next_node++;
        end
        steady = 1'b0;
        issue_command(FN_INSERT, 31'd0, 12'd3900, '0);
        issue_command(FN_INSERT, 31'h7FFF_FFFE, 12'd0, '0);
        // A refused insert into a full bucket raises neither flag.
        issue_command(FN_INSERT, 31'h7FFF_FFFF, 12'd1024, '0);
        issue_command(FN_READ, 31'd7, '0, 10'h3FF);
        issue_command(FN_READ, 31'd8, '0, 10'd0);
        issue_command(FN_READ, NUM_W'($urandom), '0, POS_W'($urandom));
        issue_command(FN_QUERY, '0, '0, '0);
        // Let every result come home before the long clear goes in.
        quiesce();
        issue_command(FN_CLEAR, 31'd3, '0, '0);
        issue_command(FN_QUERY, '0, '0, '0);
    endtask

    // One phase of traffic shaped like a delta-stepping run: most inserts go a
    // little ahead of the current bucket, the current bucket gets cleared and
    // the frontier moves on. Stray inserts, reads and queries are mixed in.
    task automatic run_traffic(int unsigned count, logic [CFG_W-1:0] step,
                               logic [CFG_W-1:0] weight, bit far_range);
        int unsigned       i;
        int unsigned       roll;
        int unsigned       fill;
        func_t             op;
        logic [NUM_W-1:0]  num;
        logic [NUM_W-1:0]  near;
        logic [NUM_W-1:0]  frontier;
        logic [NODE_W-1:0] nd;
        logic [POS_W-1:0]  pos;
        configure(step, weight);
        // Start each phase from an empty ring.
        for (i = 0; i < ring_len; i++)
            issue_command(FN_CLEAR, NUM_W'(i), NODE_W'($urandom), POS_W'($urandom));
        if (far_range)
            frontier = NUM_W'($urandom_range(32'h7FFF_F000, 32'h7FFF_FE00));
        else
            frontier = NUM_W'($urandom_range(0, 5000));
        for (i = ring_len; i < count; i++)
        begin
            roll = $urandom_range(99);
            nd   = ($urandom_range(99) < 40) ? NODE_W'($urandom_range(63)) : NODE_W'($urandom);
            pos  = POS_W'($urandom);
            near = frontier + NUM_W'($urandom_range(0, 2 * ring_len));
            if (roll < 50)
            begin
                op  = FN_INSERT;
                num = ($urandom_range(99) < 8) ? NUM_W'($urandom) : near;
            end
            else if (roll < 62)
            begin
                op  = FN_CLEAR;
                num = ($urandom_range(99) < 75) ? frontier : near;
                if (num == frontier && $urandom_range(1) == 1)
                    frontier++;
            end
            else if (roll < 82)
            begin
                op   = FN_READ;
                num  = near;
                fill = bucket_count[num % ring_len];
                if (fill != 0 && $urandom_range(99) < 80)
                    pos = POS_W'($urandom_range(0, fill - 1));
            end
            else
            begin
                op  = FN_QUERY;
                num = ($urandom_range(99) < 20) ? NUM_W'($urandom) : near;
            end
            issue_command(op, num, nd, pos);
        end
    endtask

    task automatic test_random_traffic();
        run_traffic(170, 16'd1, 16'hFFFF, 1'b1);
        run_traffic(170, 16'hFFFF, 16'hFFFF, 1'b0);
        run_traffic(170, 16'd0, 16'd9, 1'b0);
        run_traffic(170, 16'd5, 16'd200, 1'b0);
        run_traffic(170, CFG_W'($urandom_range(1, 40)), CFG_W'($urandom_range(0, 2000)), 1'b0);
    endtask

    initial
    begin
        int k;
        in_ch.valid         = 1'b0;
        in_ch.func          = FN_INSERT;
        in_ch.bucket_number = '0;
        in_ch.node          = '0;
        in_ch.entry_pos     = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = REG_STEP_WIDTH;
        cfg_ch.data         = '0;
        out_ch.ready        = 1'b0;
        mismatches          = 0;
        quiet_cycles        = 0;
        stall_left          = 0;
        steady              = 1'b0;
        for (k = 0; k < NODE_COUNT; k++)
            node_record[k] = REC_NONE;
        for (k = 0; k < BUCKETS; k++)
            bucket_count[k] = 0;
        step_reg   = STEP_WIDTH_RST;
        weight_reg = MAX_WEIGHT_RST;
        update_ring();

        rst_n = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_state();
        test_insert_rules();
        test_ring_config();
        test_full_bucket();
        test_random_traffic();

        // Drain, then leave room for any stray result to show up.
        quiesce();
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("delta_stepping_bucket_store_core: match");
        else
            $display("delta_stepping_bucket_store_core: mismatch");
        $finish;
    end

endmodule
